FILE: rtl/mmb_pkg.sv
// Package: sizes, register indexes and field widths of the int8 matmul block.
`timescale 1ns / 1ps
`default_nettype none
package mmb_pkg;

    localparam int MAX_N = 64;
    localparam int MAX_K = 256;

    localparam int CMD_W    = 1;
    localparam int ROW_W    = 9;
    localparam int COL_W    = 6;
    localparam int DATA_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int KD_W     = 9;
    localparam int NC_W     = 7;
    localparam int CNT_W    = 9;
    localparam int PROD_W   = 2 * DATA_W;

    localparam int W_DEPTH  = (MAX_K + 1) * MAX_N;
    localparam int W_ADDR_W = $clog2(W_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_K_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_N_COLS  = 2'd1;

    localparam logic CMD_WEIGHT     = 1'b0;
    localparam logic CMD_ACTIVATION = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/mmb_if.sv
// Interfaces: input, result and configuration channels of the int8 matmul block.
`timescale 1ns / 1ps
`default_nettype none
interface mmb_in_if import mmb_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [ROW_W-1:0]         w_row;
    logic [COL_W-1:0]         w_col;
    logic signed [DATA_W-1:0] data;

    modport source (output valid, cmd, w_row, w_col, data, input ready);
    modport sink   (input valid, cmd, w_row, w_col, data, output ready);
endinterface

interface mmb_out_if import mmb_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [COL_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;

    modport source (output valid, out_col, out_value, out_last, input ready);
    modport sink   (input valid, out_col, out_value, out_last, output ready);
endinterface

interface mmb_cfg_if import mmb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/int8_matmul_bias_int32.sv
// Top level: weight-stationary int8 matrix multiply with bias row, int32 results.
`timescale 1ns / 1ps
`default_nettype none
// Weights and the bias row sit in a (MAX_K+1) x MAX_N byte RAM; accumulators sit in a
// MAX_N x 32 RAM. A weight write (cmd 0) goes straight into the weight RAM. An activation
// element sweeps all MAX_N columns through the accumulator RAM, one column per cycle
// (read, multiply-add, write back); the first element of a row adds a bias load sweep
// before it. The element that completes a row then streams n_cols results, each read
// from the accumulator RAM and registered before the next column is read. Neither RAM
// needs a clearing pass after reset. Configuration is taken on any cycle.
module int8_matmul_bias_int32 import mmb_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mmb_cfg_if.sink     i_cfg,
    mmb_in_if.sink      i_in,
    mmb_out_if.source   o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BIAS = 3'd1;
    localparam logic [2:0] S_BFIN = 3'd2;
    localparam logic [2:0] S_MAC  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_ORD  = 3'd5;
    localparam logic [2:0] S_OCAP = 3'd6;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_N - 1);

    logic [2:0]                r_state;
    logic [COL_W-1:0]          r_j;
    logic [CNT_W-1:0]          r_cnt;
    logic [KD_W-1:0]           r_k_depth;
    logic [NC_W-1:0]           r_n_cols;
    logic signed [DATA_W-1:0]  r_act;
    logic [W_ADDR_W-1:0]       r_row_base;

    logic [DATA_W-1:0]         r_wmem [W_DEPTH];
    logic [DATA_W-1:0]         r_w_q;
    logic [VALUE_W-1:0]        r_acc_mem [MAX_N];
    logic [VALUE_W-1:0]        r_acc_q;

    logic                      r_p_valid;
    logic                      r_p_bias;
    logic [COL_W-1:0]          r_p_col;

    logic                      r_out_valid;
    logic [COL_W-1:0]          r_out_col;
    logic [VALUE_W-1:0]        r_out_value;
    logic                      r_out_last;

    logic                      in_acc;
    logic                      out_acc;
    logic                      cfg_acc;
    logic [KD_W-1:0]           kd;
    logic [NC_W-1:0]           nc;
    logic                      w_we;
    logic [W_ADDR_W-1:0]       w_waddr;
    logic                      w_re;
    logic [W_ADDR_W-1:0]       w_raddr;
    logic                      a_re;
    logic signed [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0]        acc_wdata;
    logic                      out_load;
    logic                      col_last;
    logic                      row_done;

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = o_out.valid & o_out.ready;
    assign cfg_acc = i_cfg.valid & i_cfg.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_k_depth == '0) begin
            kd = KD_W'(1);
        end else if (r_k_depth > KD_W'(MAX_K)) begin
            kd = KD_W'(MAX_K);
        end else begin
            kd = r_k_depth;
        end
        if (r_n_cols == '0) begin
            nc = NC_W'(1);
        end else if (r_n_cols > NC_W'(MAX_N)) begin
            nc = NC_W'(MAX_N);
        end else begin
            nc = r_n_cols;
        end
    end

    assign w_we    = in_acc && (i_in.cmd == CMD_WEIGHT) && (i_in.w_row <= ROW_W'(MAX_K))
                     && ({1'b0, i_in.w_col} < NC_W'(MAX_N));
    assign w_waddr = W_ADDR_W'(i_in.w_row) * W_ADDR_W'(MAX_N) + W_ADDR_W'(i_in.w_col);
    assign w_re    = (r_state == S_BIAS) || (r_state == S_MAC);
    assign w_raddr = (r_state == S_BIAS) ? W_ADDR_W'(r_j) : r_row_base + W_ADDR_W'(r_j);
    assign a_re    = (r_state == S_MAC) || (r_state == S_ORD);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= i_in.data;
        end
        if (w_re) begin
            r_w_q <= r_wmem[w_raddr];
        end
    end

    assign prod      = r_act * $signed(r_w_q);
    assign acc_wdata = r_p_bias ? {{(VALUE_W - DATA_W){r_w_q[DATA_W-1]}}, r_w_q}
                                : r_acc_q + {{(VALUE_W - PROD_W){prod[PROD_W-1]}}, prod};

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_acc_mem[r_p_col] <= acc_wdata;
        end
        if (a_re) begin
            r_acc_q <= r_acc_mem[r_j];
        end
    end

    assign col_last = ((NC_W'(r_j) + NC_W'(1)) == nc);
    assign out_load = (r_state == S_OCAP) && (!r_out_valid || out_acc);
    assign row_done = ((10'(r_cnt) + 10'd1) >= 10'(kd));

    always_ff @(posedge i_clk) begin
        r_p_bias <= (r_state == S_BIAS);
        r_p_col  <= r_j;
        if (r_state == S_IDLE && in_acc && i_in.cmd == CMD_ACTIVATION) begin
            r_act      <= i_in.data;
            r_row_base <= (W_ADDR_W'(r_cnt) + W_ADDR_W'(1)) * W_ADDR_W'(MAX_N);
        end
        if (out_load) begin
            r_out_col   <= r_j;
            r_out_value <= r_acc_q;
            r_out_last  <= col_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_cnt       <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_k_depth   <= KD_W'(1);
            r_n_cols    <= NC_W'(1);
        end else begin
            r_p_valid <= (r_state == S_BIAS) || (r_state == S_MAC);

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_acc) begin
                case (i_cfg.index)
                    REG_K_DEPTH: r_k_depth <= i_cfg.wdata[KD_W-1:0];
                    REG_N_COLS:  r_n_cols  <= i_cfg.wdata[NC_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.cmd == CMD_ACTIVATION) begin
                        r_j     <= '0;
                        r_state <= (r_cnt == '0) ? S_BIAS : S_MAC;
                    end
                end
                S_BIAS: begin
                    if (r_j == LAST_COL) begin
                        r_j     <= '0;
                        r_state <= S_BFIN;
                    end else begin
                        r_j <= r_j + COL_W'(1);
                    end
                end
                S_BFIN: r_state <= S_MAC;
                S_MAC: begin
                    if (r_j == LAST_COL) begin
                        r_j     <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_j <= r_j + COL_W'(1);
                    end
                end
                S_FIN: begin
                    if (row_done) begin
                        r_cnt   <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_ORD: r_state <= S_OCAP;
                S_OCAP: begin
                    if (out_load) begin
                        if (col_last) begin
                            r_j     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + COL_W'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_col   = r_out_col;
    assign o_out.out_value = r_out_value;
    assign o_out.out_last  = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(MAX_K))
        else $error("element count reached the store depth");

    a_wb_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_state != S_IDLE))
        else $error("accumulator write-back pending while idle");

    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.cmd == CMD_ACTIVATION && r_cnt == '0) |=> (r_state == S_BIAS))
        else $error("row start did not load the bias row");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench: int8 matmul with bias row, checked against a column-parallel MAC predictor.
`timescale 1ns / 1ps
module testbench;
    import mmb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 3 * MAX_N;
    localparam int FILL_ROWS     = 3;
    localparam int RANDOM_ITEMS  = 120;
    localparam int QUIET_ITEMS   = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_column_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mmb_in_if  in_if ();
    mmb_out_if out_if ();
    mmb_cfg_if cfg_if ();

    int8_matmul_bias_int32 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state
    logic signed [DATA_W-1:0]  weight_bytes [W_DEPTH];
    logic signed [VALUE_W-1:0] col_acc [MAX_N];
    int                        elem_count;
    logic [KD_W-1:0]           k_depth_reg;
    logic [NC_W-1:0]           n_cols_reg;
    t_column_result            pending_columns [$];

    int  mismatches;
    int  weight_writes;
    int  ignored_writes;
    int  activations;
    int  rows_done;
    int  columns_checked;
    int  shapes_used;
    int  stall_left;
    int  cycle_count;
    bit  quiet_tail;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_columns.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int clamp_to(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void store_weight(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                         logic signed [DATA_W-1:0] val);
        weight_writes++;
        if (row <= MAX_K)
            weight_bytes[row * MAX_N + col] = val;
        else
            ignored_writes++;
    endfunction

    function automatic void accumulate_element(logic signed [DATA_W-1:0] a);
        int                        kd;
        int                        nc;
        int                        j;
        logic signed [VALUE_W-1:0] prod;
        t_column_result            r;
        kd = clamp_to(int'(k_depth_reg), MAX_K);
        nc = clamp_to(int'(n_cols_reg), MAX_N);
        if (elem_count == 0)
            for (j = 0; j < MAX_N; j++)
                col_acc[j] = weight_bytes[j];
        for (j = 0; j < MAX_N; j++) begin
            prod = a * weight_bytes[(elem_count + 1) * MAX_N + j];
            col_acc[j] = col_acc[j] + prod;
        end
        activations++;
        elem_count++;
        if (elem_count >= kd) begin
            elem_count = 0;
            rows_done++;
            for (j = 0; j < nc; j++) begin
                r.col   = COL_W'(j);
                r.value = col_acc[j];
                r.last  = (j == nc - 1);
                pending_columns.push_back(r);
            end
        end
    endfunction

    // entered and left at a rising edge; valid stays high after acceptance
    task automatic send_item(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic signed [DATA_W-1:0] val);
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 18);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd   <= cmd;
        in_if.w_row <= row;
        in_if.w_col <= col;
        in_if.data  <= val;
        do @(posedge i_clk); while (!in_if.ready);
        if (cmd == CMD_WEIGHT)
            store_weight(row, col, val);
        else
            accumulate_element(val);
    endtask

    task automatic drain_and_settle();
        in_if.valid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_K_DEPTH: k_depth_reg = val[KD_W-1:0];
            REG_N_COLS:  n_cols_reg  = val[NC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_shape(logic [CFG_DATA_W-1:0] k, logic [CFG_DATA_W-1:0] n);
        write_register(REG_K_DEPTH, k);
        write_register(REG_N_COLS, n);
        shapes_used++;
    endtask

    // bias row and every weight row a row can reach here, each entry written once
    task automatic test_store_fill();
        int r;
        int c;
        for (r = 0; r <= FILL_ROWS; r++)
            for (c = 0; c < MAX_N; c++)
                send_item(CMD_WEIGHT, ROW_W'(r), COL_W'(c), DATA_W'($urandom));
        drain_and_settle();
    endtask

    task automatic test_reset_shape();
        send_item(CMD_ACTIVATION, ROW_W'($urandom), COL_W'($urandom), 8'sd77);
        send_item(CMD_ACTIVATION, 9'h1FF, 6'h3F, 8'shFF);
        drain_and_settle();
    endtask

    task automatic test_value_extremes();
        set_shape(9'd2, 9'd64);
        send_item(CMD_WEIGHT, 9'd0, 6'd0, 8'sh80);
        send_item(CMD_WEIGHT, 9'd0, 6'd63, 8'sh7F);
        send_item(CMD_WEIGHT, 9'd1, 6'd0, 8'sh80);
        send_item(CMD_WEIGHT, 9'd2, 6'd0, 8'sh80);
        send_item(CMD_WEIGHT, 9'd1, 6'd63, 8'sh7F);
        send_item(CMD_WEIGHT, 9'd2, 6'd63, 8'sh7F);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sh80);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sh80);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sh7F);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sh7F);
        drain_and_settle();
    endtask

    task automatic test_ignored_writes();
        send_item(CMD_WEIGHT, 9'd257, 6'd0, 8'sh55);
        send_item(CMD_WEIGHT, 9'h1FF, 6'h3F, 8'shAA);
        send_item(CMD_WEIGHT, 9'd256, 6'h3F, 8'sh81);
        send_item(CMD_ACTIVATION, 9'd257, 6'd0, 8'sh01);
        send_item(CMD_ACTIVATION, 9'h1FF, 6'h3F, 8'sh01);
        drain_and_settle();
    endtask

    task automatic test_midrow_weights();
        set_shape(9'd3, 9'd5);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sd3);
        send_item(CMD_WEIGHT, 9'd2, 6'd1, 8'sh7F);
        send_item(CMD_WEIGHT, 9'd0, 6'd1, 8'sh12);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, -8'sd3);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sd5);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sd1);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sd1);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sd1);
        drain_and_settle();
    endtask

    task automatic test_register_saturation();
        set_shape(9'd0, 9'd0);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sh40);
        drain_and_settle();
        set_shape(9'd1, 9'd127);
        write_register(REG_UNMAPPED, 9'h1FF);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, -8'sd7);
        drain_and_settle();
    endtask

    // depth lowered below the element count mid-row: next element closes the row
    task automatic test_midrow_config();
        set_shape(9'h1FF, 9'd3);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sd11);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, -8'sd12);
        drain_and_settle();
        write_register(REG_K_DEPTH, 9'd1);
        send_item(CMD_ACTIVATION, 9'd0, 6'd0, 8'sd13);
        drain_and_settle();
    endtask

    task automatic test_random_rows();
        int                      counted;
        int                      phase;
        int                      kd;
        int                      rows;
        int                      len;
        int                      r;
        int                      e;
        logic [CFG_DATA_W-1:0]   k;
        logic [CFG_DATA_W-1:0]   n;
        logic [ROW_W-1:0]        wrow;
        logic signed [DATA_W-1:0] a;
        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            if (phase == 0) begin
                k = CFG_DATA_W'(FILL_ROWS);
                n = 9'h07F;
            end else begin
                case ($urandom_range(0, 9))
                    0:       k = 9'd0;
                    default: k = CFG_DATA_W'($urandom_range(1, FILL_ROWS));
                endcase
                case ($urandom_range(0, 7))
                    0:       n = 9'd0;
                    1:       n = CFG_DATA_W'($urandom_range(MAX_N + 1, 127));
                    2, 3:    n = CFG_DATA_W'($urandom_range(1, 4));
                    default: n = CFG_DATA_W'($urandom_range(1, MAX_N));
                endcase
            end
            set_shape(k, n);
            kd   = clamp_to(int'(k), MAX_K);
            rows = (phase == 0) ? 1 : $urandom_range(1, 4);
            for (r = 0; r < rows; r++) begin
                len = kd;
                // broken row left open for the next shape
                if (phase != 0 && r == rows - 1 && $urandom_range(0, 3) == 0)
                    len = $urandom_range(1, kd);
                for (e = 0; e < len; e++) begin
                    quiet_tail = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
                    if ($urandom_range(0, 7) == 0) begin
                        if ($urandom_range(0, 5) == 0)
                            wrow = ROW_W'($urandom_range(MAX_K + 1, 511));
                        else
                            wrow = ROW_W'($urandom_range(0, MAX_K));
                        send_item(CMD_WEIGHT, wrow, COL_W'($urandom), DATA_W'($urandom));
                        if (wrow <= MAX_K)
                            counted++;
                    end
                    if ($urandom_range(0, 7) == 0)
                        a = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
                    else
                        a = DATA_W'($urandom);
                    send_item(CMD_ACTIVATION, ROW_W'($urandom), COL_W'($urandom), a);
                    counted++;
                end
            end
            drain_and_settle();
            phase++;
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 17);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_column_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            columns_checked++;
            if (pending_columns.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: unexpected result col %0d value %0d last %0b",
                             out_if.out_col, out_if.out_value, out_if.out_last);
                mismatches++;
            end else begin
                want = pending_columns.pop_front();
                if (out_if.out_col !== want.col || out_if.out_value !== want.value ||
                    out_if.out_last !== want.last) begin
                    if (mismatches < 10)
                        $display({"ERROR: result %0d expected col %0d value %0d last %0b,",
                                  " got col %0d value %0d last %0b"},
                                 columns_checked, want.col, want.value, want.last,
                                 out_if.out_col, out_if.out_value, out_if.out_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.cmd    = CMD_WEIGHT;
        in_if.w_row  = '0;
        in_if.w_col  = '0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_K_DEPTH;
        cfg_if.wdata = '0;
        out_if.ready = 1'b0;
        stall_left   = 0;
        quiet_tail   = 1'b0;
        elem_count   = 0;
        k_depth_reg  = KD_W'(1);
        n_cols_reg   = NC_W'(1);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_store_fill();
        test_reset_shape();
        test_value_extremes();
        test_ignored_writes();
        test_midrow_weights();
        test_register_saturation();
        test_midrow_config();
        test_random_rows();
        drain_and_settle();

        $display("Covered %0d weight writes (%0d outside the store), %0d activations, %0d rows",
                 weight_writes, ignored_writes, activations, rows_done);
        $display("Checked %0d column results over %0d register settings, %0d mismatches",
                 columns_checked, shapes_used, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
